// ===== rtl/tslb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Table search package
// Shared constants, opcodes and beat types for the table search engine.
// ----------------------------------------------------------------------------
package tslb_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = ADDR_W + 1;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned IDX_W       = 10;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_BINARY = 1'b1;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [WORD_W-1:0] item_value;
  } in_beat_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] match_index;
  } out_beat_t;

  typedef struct packed {
    logic      valid;
    out_beat_t data;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/tslb_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Table search engine core
// Table memory, entry count and the linear / binary search sequencer.
// ----------------------------------------------------------------------------
module tslb_engine (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    mode_i,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  tslb_pkg::in_beat_t     in_data_i,
  output tslb_pkg::res_t         res_o,
  input  wire                    res_take_i
);

  localparam int unsigned CNT_W  = tslb_pkg::CNT_W;
  localparam int unsigned ADDR_W = tslb_pkg::ADDR_W;
  localparam int unsigned WORD_W = tslb_pkg::WORD_W;
  localparam int unsigned IDX_W  = tslb_pkg::IDX_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LIN  = 3'd1;
  localparam logic [2:0] S_BRD  = 3'd2;
  localparam logic [2:0] S_BCMP = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]               state_q, state_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic signed [WORD_W-1:0] key_q, key_d;
  logic [CNT_W-1:0]         addr_q, addr_d;
  logic [CNT_W-1:0]         lo_q, lo_d;
  logic [CNT_W-1:0]         hi_q, hi_d;
  logic [ADDR_W-1:0]        mid_q, mid_d;
  logic                     rd_vld_q, rd_vld_d;
  logic [ADDR_W-1:0]        rd_idx_q, rd_idx_d;
  tslb_pkg::out_beat_t      res_q, res_d;

  logic [WORD_W-1:0]        mem_q [tslb_pkg::TABLE_DEPTH];
  logic signed [WORD_W-1:0] rd_data_q;

  logic              accept;
  logic              full;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CNT_W:0]    mid_sum;
  logic              lin_issue;
  logic              lin_hit;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CNT_W'(tslb_pkg::TABLE_DEPTH));
  assign mem_we     = accept && (in_data_i.opcode == tslb_pkg::OP_APPEND) && !full;

  // floor((lo + hi_incl) / 2) with hi_q held one past the last index
  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q} - (CNT_W+1)'(1);
  assign mem_raddr = (state_q == S_BRD) ? mid_sum[ADDR_W:1] : addr_q[ADDR_W-1:0];

  assign lin_issue = (addr_q < count_q);
  assign lin_hit   = rd_vld_q && (rd_data_q == key_q);

  assign res_o.valid = (state_q == S_DONE);
  assign res_o.data  = res_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[count_q[ADDR_W-1:0]] <= in_data_i.item_value;
    end
    rd_data_q <= mem_q[mem_raddr];
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    key_d    = key_q;
    addr_d   = addr_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    rd_vld_d = 1'b0;
    rd_idx_d = rd_idx_q;
    res_d    = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data_i.opcode)
            tslb_pkg::OP_APPEND: begin
              if (!full) begin
                count_d = count_q + CNT_W'(1);
              end
            end
            tslb_pkg::OP_SEARCH: begin
              key_d   = in_data_i.item_value;
              addr_d  = '0;
              lo_d    = '0;
              hi_d    = count_q;
              state_d = (mode_i == tslb_pkg::MODE_BINARY) ? S_BRD : S_LIN;
            end
            tslb_pkg::OP_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_LIN: begin
        if (lin_hit) begin
          res_d.found       = 1'b1;
          res_d.match_index = IDX_W'(rd_idx_q);
          state_d           = S_DONE;
        end else if (lin_issue) begin
          rd_vld_d = 1'b1;
          rd_idx_d = addr_q[ADDR_W-1:0];
          addr_d   = addr_q + CNT_W'(1);
        end else begin
          res_d   = '0;
          state_d = S_DONE;
        end
      end
      S_BRD: begin
        if (lo_q < hi_q) begin
          mid_d   = mid_sum[ADDR_W:1];
          state_d = S_BCMP;
        end else begin
          res_d   = '0;
          state_d = S_DONE;
        end
      end
      S_BCMP: begin
        if (rd_data_q == key_q) begin
          res_d.found       = 1'b1;
          res_d.match_index = IDX_W'(mid_q);
          state_d           = S_DONE;
        end else begin
          if (rd_data_q < key_q) begin
            lo_d = CNT_W'(mid_q) + CNT_W'(1);
          end else begin
            hi_d = CNT_W'(mid_q);
          end
          state_d = S_BRD;
        end
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    addr_q   <= addr_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    rd_idx_q <= rd_idx_d;
    res_q    <= res_d;
  end

endmodule
`default_nettype wire

// ===== rtl/table_search_linear_binary_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Table search engine, top level
// Sequencing: append and clear act in the idle state; a linear search reads
//   from index 0 to the first match, a binary search reads and compares the
//   middle word on each probe; the output register takes the result.
// Throughput: one beat in flight at a time, bounded by the single table read
//   port (one word compared per cycle in linear mode).
// Reset: entry count 0, linear mode, no result pending; table words undefined.
// ----------------------------------------------------------------------------
module table_search_linear_binary_top (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    cfg_we_i,
  input  wire                    cfg_wdata_i,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  tslb_pkg::in_beat_t     in_data_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output tslb_pkg::out_beat_t    out_data_o
);

  logic                mode_q;
  logic                out_valid_q, out_valid_d;
  tslb_pkg::out_beat_t out_data_q;
  tslb_pkg::res_t      res;
  logic                res_take;

  tslb_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mode_i     (mode_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .res_o      (res),
    .res_take_i (res_take)
  );

  assign res_take = res.valid && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= tslb_pkg::MODE_LINEAR;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_data_q <= res.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_data_i.opcode == tslb_pkg::OP_SEARCH))
    |=> !in_ready_o)
    else $error("search beat accepted but engine still ready");

  a_result_frees_engine: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result loaded but engine not back to idle");

  a_miss_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.found) |-> (out_data_o.match_index == '0))
    else $error("miss result with nonzero index");

endmodule
`default_nettype wire

// ===== tb/sv/tb_table_search_linear_binary_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table search engine testbench
// Drives append, search, clear and unused-opcode beats through the valid/ready
// input and checks every search result against a scoreboard. A behavioral
// table in the bench mirrors the loaded words and the search mode. The run
// covers linear and binary mode, sorted and unsorted loads, duplicates, empty
// tables, extreme words, random idling on both sides and back-pressure.
// ----------------------------------------------------------------------------
module tb_table_search_linear_binary_top;

  localparam logic [1:0]  OP_UNUSED      = 2'd3;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned END_CYCLES     = 40;
  localparam int unsigned HOLD_CYCLES    = 300;
  // several times a full-table linear scan plus the long hold
  localparam int unsigned WATCHDOG_LIMIT = 10000;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic                cfg_wdata = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  tslb_pkg::in_beat_t  in_beat   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  tslb_pkg::out_beat_t out_beat;

  // bench copy of the block state
  int          tbl_words [tslb_pkg::TABLE_DEPTH];
  int unsigned n_loaded    = 0;
  logic        active_mode = tslb_pkg::MODE_LINEAR;

  tslb_pkg::in_beat_t  beat_backlog_q [$];
  tslb_pkg::out_beat_t due_results_q  [$];
  int unsigned pushed_cnt    = 0;
  int unsigned accepted_cnt  = 0;
  bit          in_taken      = 1'b0;
  int unsigned send_idle_pct = 10;
  int unsigned recv_idle_pct = 79;
  int unsigned hold_request  = 0;
  int unsigned hold_left     = 0;
  int unsigned stall_cycles  = 0;
  int unsigned err_cnt       = 0;
  int unsigned n_checked     = 0;
  int unsigned n_hits        = 0;
  int unsigned n_binary      = 0;

  table_search_linear_binary_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_beat)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t ns: %s got %0d, want %0d", $time, what, got, want);
    err_cnt++;
  endtask

  function automatic tslb_pkg::out_beat_t search_table(input int key);
    tslb_pkg::out_beat_t r;
    longint              lo;
    longint              hi;
    longint              mid;
    r = '0;
    if (active_mode == tslb_pkg::MODE_LINEAR) begin
      for (int unsigned i = 0; i < n_loaded; i++) begin
        if (tbl_words[i] == key) begin
          r.found       = 1'b1;
          r.match_index = i[tslb_pkg::IDX_W-1:0];
          return r;
        end
      end
    end else begin
      lo = 0;
      hi = longint'(n_loaded) - 1;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (tbl_words[mid] == key) begin
          r.found       = 1'b1;
          r.match_index = mid[tslb_pkg::IDX_W-1:0];
          return r;
        end
        if (tbl_words[mid] < key) lo = mid + 1;
        else hi = mid - 1;
      end
    end
    return r;
  endfunction

  function automatic void model_beat(input tslb_pkg::in_beat_t b);
    case (b.opcode)
      tslb_pkg::OP_APPEND: begin
        if (n_loaded < tslb_pkg::TABLE_DEPTH) begin
          tbl_words[n_loaded] = b.item_value;
          n_loaded++;
        end
      end
      tslb_pkg::OP_SEARCH: begin
        due_results_q = {due_results_q, search_table(b.item_value)};
        if (active_mode == tslb_pkg::MODE_BINARY) n_binary++;
      end
      tslb_pkg::OP_CLEAR: n_loaded = 0;
      default: ;
    endcase
  endfunction

  // input side: driver at the falling edge, acceptance at the rising edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (beat_backlog_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_beat  <= beat_backlog_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      model_beat(in_beat);
      accepted_cnt++;
      in_taken = 1'b1;
    end
  end

  // output side: ready at the falling edge, long hold when requested
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    tslb_pkg::out_beat_t due;
    if (rst_n && out_valid && out_ready) begin
      if (due_results_q.size() == 0) begin
        flag_mismatch("result beat with no search pending, match_index",
                      out_beat.match_index, 0);
      end else begin
        due = due_results_q.pop_front();
        n_checked++;
        if (due.found) n_hits++;
        if (out_beat.found !== due.found)
          flag_mismatch("found", out_beat.found, due.found);
        if (out_beat.match_index !== due.match_index)
          flag_mismatch("match_index", out_beat.match_index, due.match_index);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no beat moved for %0d cycles", stall_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic push_beat(input logic [1:0] op, input int val);
    tslb_pkg::in_beat_t b;
    b.opcode       = op;
    b.item_value   = val;
    beat_backlog_q = {beat_backlog_q, b};
    pushed_cnt++;
  endtask

  function automatic int pick_word();
    case ($urandom_range(3))
      0: return int'($urandom_range(15)) - 8;
      1: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 0;
          default: return -1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // one load-then-search sequence; mostly starts from an empty table
  task automatic queue_round(input bit sorted, input int unsigned max_len);
    int words [$];
    int unsigned n_words;
    int unsigned n_srch;
    int key;
    if ($urandom_range(9) != 0) push_beat(tslb_pkg::OP_CLEAR, $urandom);
    n_words = $urandom_range(max_len);
    for (int unsigned i = 0; i < n_words; i++) words = {words, pick_word()};
    if (sorted) words.sort();
    foreach (words[i]) push_beat(tslb_pkg::OP_APPEND, words[i]);
    n_srch = $urandom_range(1, 4);
    for (int unsigned i = 0; i < n_srch; i++) begin
      if (words.size() == 0 || $urandom_range(3) == 3) begin
        key = pick_word();
      end else begin
        key = words[$urandom_range(words.size() - 1)];
        if ($urandom_range(3) == 0) key = key + int'($urandom_range(2)) - 1;
      end
      push_beat(tslb_pkg::OP_SEARCH, key);
    end
    if ($urandom_range(4) == 0) push_beat(OP_UNUSED, $urandom);
  endtask

  task automatic wait_idle();
    while (accepted_cnt != pushed_cnt || due_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
    active_mode = m;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // linear mode, directed
    push_beat(tslb_pkg::OP_SEARCH, 5);
    push_beat(tslb_pkg::OP_APPEND, 32'h8000_0000);
    push_beat(tslb_pkg::OP_APPEND, 32'h7FFF_FFFF);
    push_beat(tslb_pkg::OP_APPEND, 0);
    push_beat(tslb_pkg::OP_APPEND, -1);
    push_beat(tslb_pkg::OP_APPEND, -1);
    push_beat(tslb_pkg::OP_APPEND, 5);
    push_beat(tslb_pkg::OP_SEARCH, -1);
    push_beat(tslb_pkg::OP_SEARCH, 32'h7FFF_FFFF);
    push_beat(tslb_pkg::OP_SEARCH, 32'h8000_0000);
    push_beat(tslb_pkg::OP_SEARCH, 6);
    push_beat(OP_UNUSED, -1);
    push_beat(OP_UNUSED, 32'h5555_5555);
    push_beat(tslb_pkg::OP_SEARCH, 5);
    push_beat(tslb_pkg::OP_CLEAR, 0);
    push_beat(tslb_pkg::OP_SEARCH, 0);

    while (pushed_cnt < 160) queue_round($urandom_range(1), 16);
    wait_idle();

    // binary mode, sender idles heavily
    write_mode(tslb_pkg::MODE_BINARY);
    send_idle_pct = 79;
    recv_idle_pct = 10;
    push_beat(tslb_pkg::OP_CLEAR, 0);
    push_beat(tslb_pkg::OP_APPEND, -7);
    push_beat(tslb_pkg::OP_APPEND, 0);
    push_beat(tslb_pkg::OP_APPEND, 3);
    push_beat(tslb_pkg::OP_APPEND, 3);
    push_beat(tslb_pkg::OP_APPEND, 9);
    push_beat(tslb_pkg::OP_APPEND, 32'h7FFF_FFFF);
    push_beat(tslb_pkg::OP_SEARCH, 9);
    push_beat(tslb_pkg::OP_SEARCH, -7);
    push_beat(tslb_pkg::OP_SEARCH, 3);
    push_beat(tslb_pkg::OP_SEARCH, 4);
    push_beat(tslb_pkg::OP_SEARCH, 32'h7FFF_FFFF);
    push_beat(tslb_pkg::OP_SEARCH, 32'h8000_0000);
    while (pushed_cnt < 260) queue_round($urandom_range(9) != 0, 20);
    wait_idle();
    while (pushed_cnt < 360) queue_round($urandom_range(9) != 0, 20);
    wait_idle();

    // linear mode, no idling, long receiver hold to back up the input
    write_mode(tslb_pkg::MODE_LINEAR);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = HOLD_CYCLES;
    while (pushed_cnt < 560) queue_round($urandom_range(1), 16);
    wait_idle();

    repeat (END_CYCLES) @(posedge clk);
    if (due_results_q.size() != 0)
      flag_mismatch("searches left without a result", due_results_q.size(), 0);
    $display("Run: %0d beats in, %0d search results checked (%0d hits, %0d binary)",
             accepted_cnt, n_checked, n_hits, n_binary);
    $display("Both modes, empty tables, extreme keys, stalls on both sides");
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
